// File: rtl/core/tdpt_pkg.sv
// Shared types and constants for the trial division prime test core.
package tdpt_pkg;

   localparam int CANDIDATE_WIDTH = 32;
   localparam int PRIME_TWO       = 2;
   localparam int PRIME_THREE     = 3;
   localparam int FIRST_DIVISOR   = 5;
   localparam int PAIR_GAP        = 2;
   localparam int DIVISOR_STEP    = 6;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_stat_type;

endpackage

// File: rtl/core/tdpt_req_if.sv
// Request channel carrying one candidate item.
interface tdpt_req_if import tdpt_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CANDIDATE_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink (input valid, input candidate, output ready);
endinterface

// File: rtl/core/tdpt_rsp_if.sv
// Response channel carrying one primality verdict item.
interface tdpt_rsp_if import tdpt_pkg::*; ();
   logic valid;
   logic ready;
   logic is_prime;

   modport source (output valid, output is_prime, input ready);
   modport sink (input valid, input is_prime, output ready);
endinterface

// File: rtl/core/tdpt_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tdpt_divider import tdpt_pkg::*; #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output div_stat_type stat,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  shift_ff, shift_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  div_ff, div_in;
   logic [CW-1:0] count_ff, count_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W:0]    trial;
   logic [W:0]    diff;
   logic          fits;

   assign trial = {rem_ff, shift_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CW'(W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[W-2:0], fits};
         rem_in   = fits ? diff[W-1:0] : trial[W-1:0];
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);
   assign quotient      = shift_ff;

endmodule

// File: rtl/core/trial_division_prime_test_core.sv
// Top level: primality test of one candidate item by 6k-1 / 6k+1 trial division.
// Candidates 0..3 and even numbers are decided in the check state without a division; otherwise
// the candidate goes through a run of divisions in the shared bit-serial divider: one by 3,
// then 6k-1 and 6k+1 per pair up to sqrt(n); the last pair may end after its first one.
// Throughput: one item at a time; the next item can be taken in the cycle after the verdict is stored.
// Reset: synchronous; clears the sequencer, the divider busy flag and the response valid.
module trial_division_prime_test_core import tdpt_pkg::*; #(
   parameter int NUM_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);

   localparam int W = NUM_WIDTH;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_MOD3  = 3'd2;
   localparam logic [2:0] S_MODD  = 3'd3;
   localparam logic [2:0] S_MODD2 = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [W-1:0] num_ff, num_in;
   logic [W-1:0] d_ff, d_in;
   logic         start_ff, start_in;
   logic         result_ff, result_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_prime_ff, rsp_prime_in;

   logic [W-1:0] num_ext;
   logic [W-1:0] divisor;
   logic [W-1:0] quotient;
   div_stat_type div_stat;

   generate
      if (W >= CANDIDATE_WIDTH) begin : g_wide
         assign num_ext = W'(req_chan.candidate);
      end else begin : g_narrow
         assign num_ext = req_chan.candidate[W-1:0];
      end
   endgenerate

   assign divisor = (state_ff == S_MODD2) ? d_ff + W'(PAIR_GAP) : d_ff;

   tdpt_divider #(.W(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (num_ff),
      .divisor  (divisor),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      d_in         = d_ff;
      start_in     = 1'b0;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               num_in   = num_ext;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (num_ff <= W'(1)) begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end else if (num_ff == W'(PRIME_TWO) || num_ff == W'(PRIME_THREE)) begin
               result_in = 1'b1;
               state_in  = S_DONE;
            end else if (!num_ff[0]) begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end else begin
               d_in     = W'(PRIME_THREE);
               start_in = 1'b1;
               state_in = S_MOD3;
            end
         end
         S_MOD3: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  d_in     = W'(FIRST_DIVISOR);
                  start_in = 1'b1;
                  state_in = S_MODD;
               end
            end
         end
         S_MODD: begin
            if (div_stat.done) begin
               if (d_ff > quotient) begin
                  result_in = 1'b1;
                  state_in  = S_DONE;
               end else if (div_stat.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  start_in = 1'b1;
                  state_in = S_MODD2;
               end
            end
         end
         S_MODD2: begin
            if (div_stat.done) begin
               if (div_stat.rem_zero) begin
                  result_in = 1'b0;
                  state_in  = S_DONE;
               end else begin
                  d_in     = d_ff + W'(DIVISOR_STEP);
                  start_in = 1'b1;
                  state_in = S_MODD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      d_ff         <= d_in;
      result_ff    <= result_in;
      rsp_prime_ff <= rsp_prime_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.is_prime = rsp_prime_ff;

endmodule

// File: rtl/core/tdpt_checker.sv
// Port-level assertions for the prime test core, bound to the top level.
module tdpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_prime
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_is_prime)))
      else $error("response item dropped or changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid set after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item taken while one is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response appeared the cycle after an item was taken");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_is_prime (rsp_chan.is_prime)
);

// File: verif/tdpt_verdict_checker.sv
// Checker for the prime test core: predicts each verdict and compares it with the response.
module tdpt_verdict_checker import tdpt_pkg::*; #(
   parameter int NUM_WIDTH = 32
) (
   input  logic  clock,
   input  logic  reset,
   tdpt_req_if   req_mon,
   tdpt_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending_count
);

   logic expected_verdicts[$];

   function automatic logic primality_of(logic [CANDIDATE_WIDTH-1:0] raw);
      logic [63:0] width_mask;
      logic [63:0] n;
      logic [63:0] d;
      width_mask = (NUM_WIDTH >= 64) ? '1 : ((64'd1 << NUM_WIDTH) - 64'd1);
      n = 64'(raw) & width_mask;
      if (n <= 64'd1) return 1'b0;
      if (n == 64'(PRIME_TWO) || n == 64'(PRIME_THREE)) return 1'b1;
      if ((n % 64'(PRIME_TWO)) == 0 || (n % 64'(PRIME_THREE)) == 0) return 1'b0;
      for (d = 64'(FIRST_DIVISOR); d <= n / d; d += 64'(DIVISOR_STEP)) begin
         if ((n % d) == 0 || (n % (d + 64'(PAIR_GAP))) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            expected_verdicts = {expected_verdicts, primality_of(req_mon.candidate)};
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_verdicts.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10)
                  $display("ERROR: unexpected verdict item is_prime=%0b", rsp_mon.is_prime);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_mon.is_prime !== want) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("ERROR: is_prime expected %0b, got %0b", want, rsp_mon.is_prime);
               end
            end
         end
         pending_count = expected_verdicts.size();
      end
   end

endmodule

// File: verif/tb_trial_division_prime_test_core.sv
// Testbench top for the prime test core: clock, reset, candidate and stall traffic, verdict.
module tb_trial_division_prime_test_core import tdpt_pkg::*; ();

   localparam int NUM_WIDTH    = 32;
   localparam int RANDOM_ITEMS = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   bit   stimulus_done = 1'b0;

   logic [CANDIDATE_WIDTH-1:0] directed_candidates[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
      32'd25, 32'd35, 32'd49, 32'd121, 32'd169, 32'd289, 32'd361,
      32'd1021, 32'd1042441, 32'd16777213, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
      32'h8000_0000, 32'h5555_5555
   };

   tdpt_req_if req_chan ();
   tdpt_rsp_if rsp_chan ();

   trial_division_prime_test_core #(
      .NUM_WIDTH (NUM_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tdpt_verdict_checker #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   function automatic logic [CANDIDATE_WIDTH-1:0] draw_candidate();
      int unsigned                sel;
      int unsigned                factors[6];
      logic [CANDIDATE_WIDTH-1:0] n;
      int unsigned                f;
      factors = '{2, 3, 5, 7, 11, 13};
      sel = $urandom_range(0, 99);
      if (sel < 60) return CANDIDATE_WIDTH'($urandom_range(0, 4095));
      if (sel < 85) return CANDIDATE_WIDTH'($urandom_range(0, 32'h000F_FFFF));
      // keep wide values quick: force a small factor
      n = $urandom();
      f = factors[$urandom_range(0, 5)];
      return n - (n % f);
   endfunction

   task automatic offer_item(input logic [CANDIDATE_WIDTH-1:0] value, input int idx);
      int gap;
      gap = (((idx / 16) % 3) == 2) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.candidate <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.candidate <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_candidates[i]) offer_item(directed_candidates[i], i);
      for (int i = 0; i < RANDOM_ITEMS; i++) offer_item(draw_candidate(), i);
      req_chan.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = (((taken / 12) % 3) == 1) ? 0 : $urandom_range(0, 9);
         // hold off long enough to back up the input side
         if (taken == 30) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      wait (stimulus_done);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: trial_division_prime_test_core.f
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_req_if.sv
rtl/core/tdpt_rsp_if.sv
rtl/core/tdpt_divider.sv
rtl/core/trial_division_prime_test_core.sv
rtl/core/tdpt_checker.sv
verif/tdpt_verdict_checker.sv
verif/tb_trial_division_prime_test_core.sv
